// ===== design/tmps_pkg.sv =====
// Shared types, widths and constants for the triangle minimum path sum block.
`default_nettype none
package tmps_pkg;

  localparam int MAX_ROWS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS + 1);
  localparam int CFG_W    = 7;
  localparam int CMP_W    = (ROW_W > CFG_W) ? ROW_W : CFG_W;
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 22;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [ROW_W-1:0]        row_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic shift;
    row_t pos;
    sum_t data;
  } tmps_ctrl_t;

endpackage
`default_nettype wire

// ===== design/triangle_min_path_sum.sv =====
// Top level: triangle minimum path sum over a chain of row-sum cells.
//
//   channel   signals                         direction
//   input     in_valid in_ready value         in
//   result    out_valid out_ready min_total   out
//   config    cfg_valid cfg_ready num_rows    in
//
// One item per cycle while in_ready is high; the path is chain head, min, add, saturate, compare.
// The result is registered in the cycle after the last item of a triangle is accepted.
// Reset sets the row count to one and restarts; the row cells need no clearing.
// in_ready drops only while a result waits and out_ready is low.
`default_nettype none
module triangle_min_path_sum
  import tmps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [VAL_W-1:0] value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output sum_t                         min_total,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_W-1:0]        num_rows
);

  logic [CFG_W-1:0] rows_cfg;
  row_t             row_index;
  row_t             col_index;
  sum_t             upper_left_sum;
  sum_t             best_sum;

  logic [CMP_W-1:0] rows_eff;
  logic             last_row;
  row_t             jc;
  logic             at_end;
  logic             accept;
  sum_t             head;
  sum_t             v_ext;
  sum_t             m;
  sum_t             upper_left_sum_next;
  logic signed [SUM_W:0] wide;
  sum_t             nsum;
  sum_t             best_cand;
  tmps_ctrl_t       ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign v_ext     = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};

  always_comb begin
    if (rows_cfg == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(rows_cfg) > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = CMP_W'(rows_cfg);
    end
    last_row = ({1'b0, CMP_W'(row_index)} + (CMP_W+1)'(1)) >= {1'b0, rows_eff};
    jc       = (col_index > row_index) ? row_index : col_index;
    at_end   = (jc == row_index);

    if (row_index == '0) begin
      m                   = '0;
      upper_left_sum_next = upper_left_sum;
    end else if (jc == '0) begin
      m                   = head;
      upper_left_sum_next = head;
    end else if (at_end) begin
      m                   = upper_left_sum;
      upper_left_sum_next = upper_left_sum;
    end else begin
      m                   = (upper_left_sum < head) ? upper_left_sum : head;
      upper_left_sum_next = head;
    end

    wide = {v_ext[SUM_W-1], v_ext} + {m[SUM_W-1], m};
    if (row_index == '0) begin
      nsum = v_ext;
    end else if (wide[SUM_W] != wide[SUM_W-1]) begin
      nsum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      nsum = wide[SUM_W-1:0];
    end

    best_cand = (last_row && (nsum < best_sum)) ? nsum : best_sum;

    ctrl.load  = accept;
    ctrl.shift = !at_end;
    ctrl.pos   = at_end ? row_index : row_index - row_t'(1);
    ctrl.data  = nsum;
  end

  tmps_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg       <= CFG_W'(1);
      row_index      <= '0;
      col_index      <= '0;
      upper_left_sum <= '0;
      best_sum       <= SUM_MAX;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rows_cfg <= num_rows;
      end
      if (accept && at_end && last_row) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (at_end && last_row) begin
          row_index      <= '0;
          col_index      <= '0;
          upper_left_sum <= '0;
          best_sum       <= SUM_MAX;
        end else begin
          upper_left_sum <= upper_left_sum_next;
          best_sum       <= best_cand;
          if (at_end) begin
            row_index <= row_index + row_t'(1);
            col_index <= '0;
          end else begin
            col_index <= jc + row_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && at_end && last_row) begin
      min_total <= best_cand;
    end
  end

endmodule
`default_nettype wire

// ===== design/tmps_cell.sv =====
// One cell of the row-sum chain: loads a new sum, takes its right neighbour's, or holds.
`default_nettype none
module tmps_cell
  import tmps_pkg::*;
(
  input  wire logic       clk,
  input  wire tmps_ctrl_t ctrl,
  input  wire row_t       idx,
  input  wire sum_t       nbr,
  output sum_t            q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.pos == idx) begin
        q <= ctrl.data;
      end else if (ctrl.shift) begin
        q <= nbr;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/tmps_chain.sv =====
// Row of cells holding the previous row's sums, head first.
`default_nettype none
module tmps_chain
  import tmps_pkg::*;
(
  input  wire logic       clk,
  input  wire tmps_ctrl_t ctrl,
  output sum_t            head
);

  sum_t q [MAX_ROWS];
  sum_t nbr [MAX_ROWS];

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    if (k == MAX_ROWS - 1) begin : g_last
      assign nbr[k] = q[k];
    end else begin : g_mid
      assign nbr[k] = q[k+1];
    end
    tmps_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .idx  (row_t'(k)),
      .nbr  (nbr[k]),
      .q    (q[k])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire
